// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the receive message id table.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define RMIT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define RMIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RMIT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RMIT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/rmit_pkg.sv =====
// Package for the receive message id table: item types, controller state,
// command and status groups. No dependencies.
package rmit_pkg;

    localparam int KEY_W   = 64;
    localparam int RX_ID_W = 6;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [15:0] sender_msg_id;
    } t_in_item;

    typedef struct packed {
        logic               success;
        logic [RX_ID_W-1:0] rx_id;
        logic               is_new_msg;
        logic               is_new_pkt;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch a new key, restart the scan
        logic scan_en;  // advance the scan by one entry
        logic finish;   // write the result, allocate on a miss if not full
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic resolved; // hit found, or every valid entry compared
        logic out_free; // output register can take a result this cycle
    } t_status;

endpackage

// ===== rtl/core/rmit_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rmit_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds while no read is issued
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/rmit_dp.sv =====
// Datapath of the receive message id table: key register, key store,
// scan pointers, allocation count and output register. Uses rmit_pkg, rmit_ram.
module rmit_dp #(
    parameter int MAX_MESSAGES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rmit_pkg::t_in_item i_in_item,
    input  rmit_pkg::t_cmd     i_cmd,
    output rmit_pkg::t_status  o_status,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output rmit_pkg::t_out_item o_out_item
);

    localparam int CNT_W = $clog2(MAX_MESSAGES + 1);
    localparam int ID_W  = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;

    logic [rmit_pkg::KEY_W-1:0] r_key;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CNT_W-1:0]           r_idx, n_idx;
    logic                       r_cmp_vld, n_cmp_vld;
    logic [ID_W-1:0]            r_cmp_idx, n_cmp_idx;
    logic                       r_out_vld, n_out_vld;
    rmit_pkg::t_out_item        r_out, n_out;

    logic [rmit_pkg::KEY_W-1:0] rd_data;
    logic                       issue;
    logic                       match;
    logic                       full;
    logic                       alloc;
    logic                       success;
    logic [ID_W-1:0]            id_sel;
    logic [ID_W+rmit_pkg::RX_ID_W-1:0] id_ext;

    assign issue = r_idx < r_count;
    assign match = r_cmp_vld && (rd_data == r_key);
    assign full  = r_count == CNT_W'(MAX_MESSAGES);
    assign alloc = !match && !full;

    assign o_status.resolved = match || !issue;
    assign o_status.out_free = !r_out_vld || i_out_ready;

    assign success = match || !full;
    assign id_sel  = match ? r_cmp_idx : r_count[ID_W-1:0];
    assign id_ext  = {{rmit_pkg::RX_ID_W{1'b0}}, id_sel};

    rmit_ram #(
        .WIDTH (rmit_pkg::KEY_W),
        .DEPTH (MAX_MESSAGES)
    ) u_key_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.finish && alloc),
        .i_wr_addr (r_count[ID_W-1:0]),
        .i_wr_data (r_key),
        .i_rd_en   (i_cmd.scan_en && issue),
        .i_rd_addr (r_idx[ID_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmp_vld = r_cmp_vld;
        n_cmp_idx = r_cmp_idx;
        n_out_vld = r_out_vld;
        n_out     = r_out;

        if (i_cmd.load) begin
            n_idx     = '0;
            n_cmp_vld = 1'b0;
        end else if (i_cmd.scan_en) begin
            // read of entry r_idx now, its compare next cycle
            n_idx     = issue ? r_idx + CNT_W'(1) : r_idx;
            n_cmp_vld = issue;
            n_cmp_idx = r_idx[ID_W-1:0];
        end

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if (i_cmd.finish) begin
            n_out_vld        = 1'b1;
            n_out.success    = success;
            n_out.rx_id      = success ? id_ext[rmit_pkg::RX_ID_W-1:0] : '0;
            n_out.is_new_msg = alloc;
            n_out.is_new_pkt = success;
            if (alloc) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= {i_in_item.src_addr, i_in_item.src_port, i_in_item.sender_msg_id};
        end
        r_cmp_idx <= n_cmp_idx;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

// ===== rtl/core/rmit_ctrl.sv =====
// Controller of the receive message id table: idle / scan state machine.
// Uses rmit_pkg.
module rmit_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rmit_pkg::t_status i_status,
    output rmit_pkg::t_cmd    o_cmd
);

    rmit_pkg::t_state r_state, n_state;

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.scan_en = 1'b0;
        o_cmd.finish  = 1'b0;
        case (r_state)
            rmit_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = rmit_pkg::ST_SCAN;
                end
            end
            rmit_pkg::ST_SCAN: begin
                // freeze the scan once resolved; hold until the output frees up
                o_cmd.scan_en = !i_status.resolved;
                if (i_status.resolved && i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = rmit_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rmit_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmit_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/rx_message_id_table.sv =====
// Receive message id table: looks up {src_addr, src_port, sender_msg_id}, allocates on a miss.
// A lookup compares the stored keys in order from id 0 and stops at the first hit; a miss
// or a full-table failure compares every allocated entry. No new item is taken until it ends.
// The key store's single read port, scanned one entry a cycle, sets how long a lookup takes.
// Reset (i_rst_n low, synchronous) empties the table and clears the output; no clearing pass.
// Uses rmit_pkg, rmit_ctrl, rmit_dp, rmit_ram and assert_macros.svh.
`include "assert_macros.svh"

module rx_message_id_table #(
    parameter int MAX_MESSAGES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rmit_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rmit_pkg::t_out_item o_out_item
);

    // Command and status between the state machine and the datapath.
    rmit_pkg::t_cmd    cmd;
    rmit_pkg::t_status status;

    // Controller: takes an item in idle, runs the scan, issues the finish
    // once the lookup has resolved and the output register is free.
    rmit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: key store RAM, pipelined compare of one stored key per cycle,
    // allocation counter and output register. The output register lets the
    // next item be taken while a result still waits for i_out_ready.
    rmit_dp #(
        .MAX_MESSAGES (MAX_MESSAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // A failed lookup carries id 0 and no allocation.
    `RMIT_ASSERT_IMPL(a_fail_clean, i_clk, i_rst_n, o_out_valid && !o_out_item.success, o_out_item.rx_id == '0 && !o_out_item.is_new_msg)
    // No packet is ever marked received, so new-packet tracks success.
    `RMIT_ASSERT_IMPL(a_new_pkt, i_clk, i_rst_n, o_out_valid, o_out_item.is_new_pkt == o_out_item.success)
    // A finished lookup shows up on the output next cycle.
    `RMIT_ASSERT_NEXT(a_finish_out, i_clk, i_rst_n, cmd.finish, o_out_valid)
    // One item at a time: after an accept the input stays closed.
    `RMIT_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

// ===== bench/tb_top.sv =====
// Testbench for rx_message_id_table: key lookup with id allocation on a miss.
// Holds a scoreboard class with its own copy of the id table, and the drivers.
// Depends on rmit_pkg and the rx_message_id_table RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_IDS    = 64;
    localparam int IDLE_PCT   = 20;
    localparam int STALL_LIMIT = 2000;  // cycles with no handshake on either side
    localparam int RAND_ITEMS = 1030;
    localparam int DRAIN_WAIT = 80;     // wait after the last expected result

    // Scoreboard: mirrors the key table and queues one expected result per item.
    class msg_id_scoreboard;
        bit [rmit_pkg::KEY_W-1:0] known_keys[MAX_IDS];
        int unsigned              ids_handed_out;
        rmit_pkg::t_out_item      expected_ids[$];
        int unsigned              mismatches;

        function new();
            ids_handed_out = 0;
            mismatches     = 0;
        endfunction

        // Look the key up among the ids handed out so far; allocate on a miss.
        function void note_key(rmit_pkg::t_in_item it);
            bit [rmit_pkg::KEY_W-1:0] key;
            bit                       hit;
            int unsigned              id;
            rmit_pkg::t_out_item      r;
            key = it;
            hit = 1'b0;
            id  = 0;
            for (int i = 0; i < ids_handed_out; i++) begin
                if (!hit && known_keys[i] == key) begin
                    hit = 1'b1;
                    id  = i;
                end
            end
            r = '0;
            if (hit) begin
                r.success    = 1'b1;
                r.rx_id      = rmit_pkg::RX_ID_W'(id);
                r.is_new_pkt = 1'b1;
            end else if (ids_handed_out < MAX_IDS) begin
                known_keys[ids_handed_out] = key;
                r.success    = 1'b1;
                r.rx_id      = rmit_pkg::RX_ID_W'(ids_handed_out);
                r.is_new_msg = 1'b1;
                r.is_new_pkt = 1'b1;
                ids_handed_out++;
            end
            // table full and no hit: all fields stay 0, state untouched
            expected_ids.push_back(r);
        endfunction

        function void check_result(rmit_pkg::t_out_item got);
            rmit_pkg::t_out_item want;
            if (expected_ids.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: success=%0d rx_id=%0d new_msg=%0d new_pkt=%0d",
                             got.success, got.rx_id, got.is_new_msg, got.is_new_pkt);
                return;
            end
            want = expected_ids[0];
            expected_ids.delete(0);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp success=%0d rx_id=%0d new_msg=%0d new_pkt=%0d",
                              " / got %0d %0d %0d %0d"},
                             want.success, want.rx_id, want.is_new_msg, want.is_new_pkt,
                             got.success, got.rx_id, got.is_new_msg, got.is_new_pkt);
            end
        endfunction

        function int unsigned pending();
            return expected_ids.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    rmit_pkg::t_in_item  in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    rmit_pkg::t_out_item out_item;

    // Set during the stretch where neither side idles.
    bit        quiet = 1'b0;
    int        no_handshake_cycles = 0;

    msg_id_scoreboard   sb = new();
    rmit_pkg::t_in_item sent_keys[$];     // keys offered so far, reused to make hits

    rx_message_id_table #(
        .MAX_MESSAGES(MAX_IDS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Offer one key after a random gap; return once it has been taken.
    // Valid is never dropped between back-to-back items, so each step sees
    // at most one update of it.
    task automatic push_key(input rmit_pkg::t_in_item it);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_key(it);
    endtask

    function automatic rmit_pkg::t_in_item random_key();
        rmit_pkg::t_in_item k;
        int                 r;
        k.src_addr = $urandom;
        k.src_port = 16'($urandom_range(16'hFFFF));
        k.sender_msg_id = 16'($urandom_range(16'hFFFF));
        // now and then pin a field to an extreme
        r = $urandom_range(15);
        case (r)
            0: k.src_addr      = '0;
            1: k.src_addr      = '1;
            2: k.src_port      = '0;
            3: k.src_port      = '1;
            4: k.sender_msg_id = '0;
            5: k.sender_msg_id = '1;
            default: ;
        endcase
        return k;
    endfunction

    // Result side: sample before the edge's updates land, then re-roll ready.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_item);
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: a hang shows up as a long run with no handshake at all.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            no_handshake_cycles <= 0;
        else
            no_handshake_cycles <= no_handshake_cycles + 1;
        if (no_handshake_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        rmit_pkg::t_in_item       it;
        bit [rmit_pkg::KEY_W-1:0] flat;
        int                       roll;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme keys, keys that differ in one field only, repeats.
        push_key('{32'h0, 16'h0, 16'h0});               // first id
        push_key('{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF});
        push_key('{32'h0, 16'h0, 16'h0});               // hit on id 0
        push_key('{32'h0, 16'h0, 16'h1});               // msg id alone differs
        push_key('{32'h0, 16'h1, 16'h0});               // port alone differs
        push_key('{32'h1, 16'h0, 16'h0});               // address alone differs
        push_key('{32'h8000_0000, 16'h0, 16'h0});
        push_key('{32'h0, 16'h8000, 16'h0});
        push_key('{32'h0, 16'h0, 16'h8000});
        push_key('{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFE});
        push_key('{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF}); // hit on id 1
        push_key('{32'h0, 16'h0, 16'h8000});            // hit on id 7
        push_key('{32'h0, 16'h1, 16'h0});
        push_key('{32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF});
        push_key('{32'h0, 16'h0, 16'h1});
        push_key('{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFE});
        sent_keys.push_back('{32'h0, 16'h0, 16'h0});
        sent_keys.push_back('{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF});
        sent_keys.push_back('{32'h0, 16'h1, 16'h0});
        sent_keys.push_back('{32'h0, 16'h0, 16'h8000});

        // Random: mostly repeats (hits), some fresh keys and one-bit neighbors
        // of known keys. The table fills part way through, so the later items
        // exercise the full-table failure alongside hits on allocated ids.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            quiet = (n >= 550 && n < 750);
            roll  = $urandom_range(99);
            if (roll < 10) begin
                it = random_key();
                sent_keys.push_back(it);
            end else if (roll < 16) begin
                flat = sent_keys[$urandom_range(sent_keys.size() - 1)];
                flat[$urandom_range(rmit_pkg::KEY_W - 1)] ^= 1'b1;
                it = flat;
                sent_keys.push_back(it);
            end else begin
                it = sent_keys[$urandom_range(sent_keys.size() - 1)];
            end
            push_key(it);
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        // Drain; the watchdog catches results that never come.
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rmit_pkg.sv
rtl/core/rmit_ram.sv
rtl/core/rmit_dp.sv
rtl/core/rmit_ctrl.sv
rtl/core/rx_message_id_table.sv
bench/tb_top.sv
